@@ sv/ede_pkg.sv @@
package ede_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int DIST_W      = 7;

  typedef enum logic [1:0] {
    REQ_APP1 = 2'd0,
    REQ_APP2 = 2'd1,
    REQ_CMP  = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] symbol;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              truncated;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // append request accepted
    logic start_cmp;  // compute request accepted
    logic calc;       // evaluate one cell
    logic clear;      // result shown, drop both strings
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic len1_zero;
    logic len2_zero;
    logic j_last;
    logic i_last;
  } stat_t;

endpackage

@@ sv/ede_ram.sv @@
module ede_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/ede_ctrl.sv @@
module ede_ctrl import ede_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] req_type,
  input  stat_t      stat,
  output logic       busy,
  output logic       out_valid,
  output ctrl_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CALC = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (req_type) inside
            REQ_APP1, REQ_APP2: cmd.load = 1'b1;
            REQ_CMP: begin
              cmd.start_cmp = 1'b1;
              state_nxt = (stat.len1_zero || stat.len2_zero) ? S_DONE : S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: state_nxt = S_CALC;
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = (stat.j_last && stat.i_last) ? S_DONE : S_RD;
      end
      S_DONE: begin
        cmd.clear = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  // RAM read issued in S_RD must be consumed in the very next cycle
  a_rd_calc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |=> state_r == S_CALC)
    else $error("read cycle not followed by cell evaluation");

  // result strobe lasts exactly one cycle
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held more than one cycle");

  // a result only follows a compute request or the last cell
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.start_cmp) || $past(cmd.calc))
    else $error("result without compute");

endmodule

@@ sv/ede_datapath.sv @@
module ede_datapath import ede_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  in_t   in_item,
  input  ctrl_t cmd,
  output stat_t stat,
  output out_t  out_item
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = LW + 1;

  logic [LW-1:0] len1_r, len2_r;
  logic          ovf_r;
  logic [LW-1:0] i_r, j_r;
  logic [LW-1:0] diag_r, left_r, dist_r;

  logic [LW-1:0] idec, jdec;
  logic [7:0]    sym1, sym2;
  logic [LW-1:0] costq;
  logic [LW-1:0] up;
  logic [CW-1:0] up_p1, left_p1, sub, m1, m2;
  logic [LW-1:0] cost_val;
  logic          full1, full2, app1, app2;
  logic [DIST_W+LW-1:0] dist_ext;

  assign idec  = i_r - LW'(1);
  assign jdec  = j_r - LW'(1);
  assign full1 = (len1_r == LW'(MAX_LEN));
  assign full2 = (len2_r == LW'(MAX_LEN));
  assign app1  = cmd.load && (in_item.req_type == REQ_APP1);
  assign app2  = cmd.load && (in_item.req_type == REQ_APP2);

  ede_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_str1 (
    .clk     (clk),
    .wr_en   (app1 && !full1),
    .wr_addr (len1_r[AW-1:0]),
    .wr_data (in_item.symbol),
    .rd_addr (idec[AW-1:0]),
    .rd_data (sym1)
  );

  ede_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_str2 (
    .clk     (clk),
    .wr_en   (app2 && !full2),
    .wr_addr (len2_r[AW-1:0]),
    .wr_data (in_item.symbol),
    .rd_addr (jdec[AW-1:0]),
    .rd_data (sym2)
  );

  // working row holds columns 1..n2; column 0 is implied by the row number
  ede_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_cost (
    .clk     (clk),
    .wr_en   (cmd.calc),
    .wr_addr (jdec[AW-1:0]),
    .wr_data (cost_val),
    .rd_addr (jdec[AW-1:0]),
    .rd_data (costq)
  );

  // first row reads the empty-prefix value j instead of the RAM
  assign up       = (i_r == LW'(1)) ? j_r : costq;
  assign up_p1    = {1'b0, up} + CW'(1);
  assign left_p1  = {1'b0, left_r} + CW'(1);
  assign sub      = {1'b0, diag_r} + CW'(sym1 != sym2);
  assign m1       = (up_p1 < left_p1) ? up_p1 : left_p1;
  assign m2       = (m1 < sub) ? m1 : sub;
  assign cost_val = m2[LW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len1_r <= '0;
      len2_r <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.clear) begin
      len1_r <= '0;
      len2_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      if (app1) begin
        if (full1) ovf_r <= 1'b1;
        else       len1_r <= len1_r + LW'(1);
      end
      if (app2) begin
        if (full2) ovf_r <= 1'b1;
        else       len2_r <= len2_r + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_cmp) begin
      i_r    <= LW'(1);
      j_r    <= LW'(1);
      diag_r <= '0;
      left_r <= LW'(1);
      dist_r <= (len1_r == '0) ? len2_r : len1_r;
    end else if (cmd.calc) begin
      dist_r <= cost_val;
      if (j_r == len2_r) begin
        i_r    <= i_r + LW'(1);
        j_r    <= LW'(1);
        diag_r <= i_r;
        left_r <= i_r + LW'(1);
      end else begin
        j_r    <= j_r + LW'(1);
        diag_r <= up;
        left_r <= cost_val;
      end
    end
  end

  assign stat.len1_zero = (len1_r == '0);
  assign stat.len2_zero = (len2_r == '0);
  assign stat.j_last    = (j_r == len2_r);
  assign stat.i_last    = (i_r == len1_r);

  assign dist_ext           = {{DIST_W{1'b0}}, dist_r};
  assign out_item.distance  = dist_ext[DIST_W-1:0];
  assign out_item.truncated = ovf_r;

  a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc |-> (j_r != '0) && (j_r <= len2_r) && (i_r != '0) && (i_r <= len1_r))
    else $error("cell index outside loaded strings");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (len1_r == '0) && (len2_r == '0) && !ovf_r)
    else $error("strings not cleared after result");

  a_len_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc |=> $stable(len1_r) && $stable(len2_r))
    else $error("lengths changed during compute");

endmodule

@@ sv/edit_distance_engine_unit.sv @@
// channel  | ports                         | handshake
// ---------+-------------------------------+--------------------------------
// request  | start, busy, in_item          | taken when start && !busy
// result   | out_valid, out_item           | one-cycle strobe, no back-pressure
//
// Append request: busy stays low.
// Compute request: busy through S_RD and S_CALC for each DP cell (one RAM
// read and one cell evaluation on the shared cost-row RAM), then S_DONE;
// with either string empty, straight to S_DONE. The result strobe is the last busy cycle.
// Reset (rst_n low, synchronous) empties both strings; no clearing pass.
// The receiver cannot stall; results are never held.
module edit_distance_engine_unit import ede_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  ctrl_t cmd;
  stat_t stat;

  ede_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_type  (in_item.req_type),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ede_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule
